FILE: design/byte_program_decrypt_interpreter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte program decrypt interpreter
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BYTE_PROGRAM_DECRYPT_INTERPRETER_MACROS_SVH
`define BYTE_PROGRAM_DECRYPT_INTERPRETER_MACROS_SVH

// Condition holds at every edge.
`define BPDI_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("bpdi invariant violated");

// Consequence holds in the same cycle as the trigger.
`define BPDI_ASSERT_SAME(label, trig, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cons)) else $error("bpdi same-cycle check failed");

// Consequence holds in the cycle after the trigger.
`define BPDI_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error("bpdi next-cycle check failed");

`endif

FILE: design/bpdi_pkg.sv
// ----------------------------------------------------------------------------
// bpdi_pkg
// Types, constants and codes shared by the byte program decrypt interpreter.
// ----------------------------------------------------------------------------
package bpdi_pkg;

    localparam int PROGRAM_LEN = 48;
    localparam int STORE_DEPTH = 64;
    localparam int MAX_STEPS   = 1024;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    // Holds any jump target: index plus 2 plus a signed byte offset
    localparam int PC_W   = 10;

    localparam logic signed [PC_W-1:0]   PC_END    = PC_W'(PROGRAM_LEN);
    localparam logic        [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_STEPS);

    // Request types
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_DATA  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_BADOP = 2'd1;
    localparam logic [1:0] STAT_STEPS = 2'd2;
    localparam logic [1:0] STAT_SKIP  = 2'd3;

    // Opcodes and mode bytes
    localparam logic [7:0] OP_JMP  = 8'hEB;
    localparam logic [7:0] OP_DEC  = 8'hFE;
    localparam logic [7:0] OP_SUBK = 8'h2A;
    localparam logic [7:0] OP_ADDK = 8'h02;
    localparam logic [7:0] OP_XORK = 8'h32;
    localparam logic [7:0] OP_ADDI = 8'h04;
    localparam logic [7:0] OP_XORI = 8'h34;
    localparam logic [7:0] OP_SUBI = 8'h2C;
    localparam logic [7:0] OP_ROTI = 8'hC0;
    localparam logic [7:0] OP_ROTK = 8'hD2;
    localparam logic [7:0] OP_NOP0 = 8'h90;
    localparam logic [7:0] OP_NOP1 = 8'hF8;
    localparam logic [7:0] OP_NOP2 = 8'hF9;
    localparam logic [7:0] MOD_ROL = 8'hC0;
    localparam logic [7:0] MOD_ROR = 8'hC8;

    // ALU functions
    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd1;
    localparam logic [2:0] FN_XOR = 3'd2;
    localparam logic [2:0] FN_ROL = 3'd3;
    localparam logic [2:0] FN_ROR = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] prog_index;
        logic [7:0] prog_byte;
        logic [7:0] run_length_low;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    typedef struct packed {
        logic [2:0] fn;
        logic [7:0] operand;
    } t_alu_ctl;

endpackage

FILE: design/byte_program_decrypt_interpreter.sv
// ----------------------------------------------------------------------------
// byte_program_decrypt_interpreter
// Runs a loaded byte-code program on each data byte and returns the result.
// ----------------------------------------------------------------------------
// Program writes and run starts are taken in idle and leave the block idle.
// A data byte is run through the program one instruction at a time: each
// instruction passes the bounds and step check and then one state per
// program byte it reads (opcode, then up to two operands), since all of
// them come through the single read port of the program store. A byte that
// leaves the program or hits the step limit ends with the last check, the
// result load and the return to idle; an unknown opcode ends right after
// its fetch with the result load. A byte after an abort goes from idle
// straight to the result load. The block is not ready while a byte is
// being interpreted or while its result waits for the output register. No
// clearing pass is needed after reset.
module byte_program_decrypt_interpreter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bpdi_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bpdi_pkg::t_out_item  o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_OPC  = 3'd2;
    localparam logic [2:0] S_OPD1 = 3'd3;
    localparam logic [2:0] S_OPD2 = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                      r_state, n_state;
    logic signed [bpdi_pkg::PC_W-1:0] r_pc, n_pc;
    logic [bpdi_pkg::STEP_W-1:0]     r_steps, n_steps;
    logic [7:0]                      r_acc, n_acc;
    logic [7:0]                      r_data, n_data;
    logic [7:0]                      r_key, n_key;
    logic                            r_aborted, n_aborted;
    logic [7:0]                      r_op, n_op;
    logic [7:0]                      r_mod, n_mod;
    logic [1:0]                      r_stat, n_stat;
    logic                            r_out_valid;
    bpdi_pkg::t_out_item             r_out;

    logic                            w_accept;
    logic                            w_load;
    logic                            w_in_range;
    logic signed [bpdi_pkg::PC_W-1:0] w_pc_p1, w_pc_p2, w_pc_p3, w_pc_jmp;
    logic [bpdi_pkg::PC_W-1:0]       w_rd_pc;
    logic [7:0]                      w_rd_data;
    bpdi_pkg::t_mem_wr               w_wr;
    bpdi_pkg::t_alu_ctl              w_alu_ctl;
    logic [7:0]                      w_alu_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign w_pc_p1  = r_pc + bpdi_pkg::PC_W'(1);
    assign w_pc_p2  = r_pc + bpdi_pkg::PC_W'(2);
    assign w_pc_p3  = r_pc + bpdi_pkg::PC_W'(3);
    assign w_pc_jmp = w_pc_p2 + {{(bpdi_pkg::PC_W-8){w_rd_data[7]}}, w_rd_data};
    assign w_in_range = (r_pc >= 0) && (r_pc < bpdi_pkg::PC_END);

    // Address the byte needed by the next state
    always_comb begin
        unique case (r_state)
            S_OPC:   w_rd_pc = w_pc_p1;
            S_OPD1:  w_rd_pc = w_pc_p2;
            default: w_rd_pc = r_pc;
        endcase
    end

    assign w_wr.en   = w_accept && (i_in.req_type == bpdi_pkg::REQ_WRITE);
    assign w_wr.addr = bpdi_pkg::ADDR_W'(i_in.prog_index);
    assign w_wr.data = i_in.prog_byte;

    bpdi_prog_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_pc[bpdi_pkg::ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // ALU control for the instruction in flight
    always_comb begin
        w_alu_ctl.fn      = bpdi_pkg::FN_ADD;
        w_alu_ctl.operand = 8'h00;
        if (r_state == S_OPC) begin
            priority case (w_rd_data)
                bpdi_pkg::OP_DEC: begin
                    w_alu_ctl.fn      = bpdi_pkg::FN_SUB;
                    w_alu_ctl.operand = 8'h01;
                end
                bpdi_pkg::OP_SUBK: begin
                    w_alu_ctl.fn      = bpdi_pkg::FN_SUB;
                    w_alu_ctl.operand = r_key;
                end
                bpdi_pkg::OP_ADDK: begin
                    w_alu_ctl.fn      = bpdi_pkg::FN_ADD;
                    w_alu_ctl.operand = r_key;
                end
                bpdi_pkg::OP_XORK: begin
                    w_alu_ctl.fn      = bpdi_pkg::FN_XOR;
                    w_alu_ctl.operand = r_key;
                end
                default: begin
                end
            endcase
        end else if (r_state == S_OPD1) begin
            w_alu_ctl.operand = w_rd_data;
            priority case (r_op)
                bpdi_pkg::OP_SUBI: w_alu_ctl.fn = bpdi_pkg::FN_SUB;
                bpdi_pkg::OP_XORI: w_alu_ctl.fn = bpdi_pkg::FN_XOR;
                bpdi_pkg::OP_ROTK: begin
                    w_alu_ctl.operand = r_key;
                    w_alu_ctl.fn      = (w_rd_data == bpdi_pkg::MOD_ROR) ?
                                        bpdi_pkg::FN_ROR : bpdi_pkg::FN_ROL;
                end
                default: w_alu_ctl.fn = bpdi_pkg::FN_ADD;
            endcase
        end else if (r_state == S_OPD2) begin
            w_alu_ctl.operand = w_rd_data;
            w_alu_ctl.fn      = (r_mod == bpdi_pkg::MOD_ROL) ?
                                bpdi_pkg::FN_ROL : bpdi_pkg::FN_ROR;
        end
    end

    bpdi_alu u_alu (
        .i_acc    (r_acc),
        .i_ctl    (w_alu_ctl),
        .o_result (w_alu_res)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_steps   = r_steps;
        n_acc     = r_acc;
        n_data    = r_data;
        n_key     = r_key;
        n_aborted = r_aborted;
        n_op      = r_op;
        n_mod     = r_mod;
        n_stat    = r_stat;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority case (i_in.req_type)
                        bpdi_pkg::REQ_START: begin
                            n_key     = i_in.run_length_low;
                            n_aborted = 1'b0;
                        end
                        bpdi_pkg::REQ_DATA: begin
                            n_data  = i_in.data_byte;
                            n_acc   = i_in.data_byte;
                            n_pc    = '0;
                            n_steps = '0;
                            if (r_aborted) begin
                                n_stat  = bpdi_pkg::STAT_SKIP;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_CHK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHK: begin
                if (!w_in_range) begin
                    n_stat  = bpdi_pkg::STAT_OK;
                    n_state = S_DONE;
                end else if (r_steps == bpdi_pkg::STEP_LIMIT) begin
                    n_stat  = bpdi_pkg::STAT_STEPS;
                    n_state = S_DONE;
                end else begin
                    n_steps = r_steps + bpdi_pkg::STEP_W'(1);
                    n_state = S_OPC;
                end
            end
            S_OPC: begin
                priority case (w_rd_data)
                    bpdi_pkg::OP_NOP0, bpdi_pkg::OP_NOP1, bpdi_pkg::OP_NOP2: begin
                        n_pc    = w_pc_p1;
                        n_state = S_CHK;
                    end
                    bpdi_pkg::OP_DEC, bpdi_pkg::OP_SUBK,
                    bpdi_pkg::OP_ADDK, bpdi_pkg::OP_XORK: begin
                        n_acc   = w_alu_res;
                        n_pc    = w_pc_p2;
                        n_state = S_CHK;
                    end
                    bpdi_pkg::OP_JMP, bpdi_pkg::OP_ADDI, bpdi_pkg::OP_XORI,
                    bpdi_pkg::OP_SUBI, bpdi_pkg::OP_ROTI, bpdi_pkg::OP_ROTK: begin
                        n_op    = w_rd_data;
                        n_state = S_OPD1;
                    end
                    default: begin
                        n_stat  = bpdi_pkg::STAT_BADOP;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_OPD1: begin
                if (r_op == bpdi_pkg::OP_JMP) begin
                    n_pc    = w_pc_jmp;
                    n_state = S_CHK;
                end else if (r_op == bpdi_pkg::OP_ROTI) begin
                    n_mod   = w_rd_data;
                    n_state = S_OPD2;
                end else begin
                    n_acc   = w_alu_res;
                    n_pc    = (r_op == bpdi_pkg::OP_ROTK) ? w_pc_p3 : w_pc_p2;
                    n_state = S_CHK;
                end
            end
            S_OPD2: begin
                n_acc   = w_alu_res;
                n_pc    = w_pc_p3;
                n_state = S_CHK;
            end
            S_DONE: begin
                if (w_load) begin
                    if (r_stat == bpdi_pkg::STAT_OK) begin
                        n_key = r_key - 8'd1;
                    end else begin
                        n_aborted = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_steps     <= '0;
            r_key       <= 8'h00;
            r_aborted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_steps   <= n_steps;
            r_key     <= n_key;
            r_aborted <= n_aborted;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc    <= n_pc;
        r_acc   <= n_acc;
        r_data  <= n_data;
        r_op    <= n_op;
        r_mod   <= n_mod;
        r_stat  <= n_stat;
        if (w_load) begin
            // Pass the input byte through on any error or skip
            r_out.plain_byte <= (r_stat == bpdi_pkg::STAT_OK) ? r_acc : r_data;
            r_out.status     <= r_stat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`include "byte_program_decrypt_interpreter_macros.svh"

    `BPDI_ASSERT_ALWAYS(a_steps_bounded, r_steps <= bpdi_pkg::STEP_LIMIT)
    `BPDI_ASSERT_NEXT(a_key_drops_on_ok, w_load && (r_stat == bpdi_pkg::STAT_OK), r_key == $past(r_key) - 8'd1)
    `BPDI_ASSERT_NEXT(a_abort_on_error, w_load && (r_stat != bpdi_pkg::STAT_OK), r_aborted && (o_out.plain_byte == $past(r_data)))
    `BPDI_ASSERT_SAME(a_skip_only_aborted, w_load && (r_stat == bpdi_pkg::STAT_SKIP), r_aborted)

endmodule

FILE: design/bpdi_prog_mem.sv
// ----------------------------------------------------------------------------
// bpdi_prog_mem
// Program store: one write and one registered read per cycle. Per-entry
// valid bits make unwritten entries read as zero right after reset.
// ----------------------------------------------------------------------------
module bpdi_prog_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpdi_pkg::t_mem_wr          i_wr,
    input  logic [bpdi_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                 o_rd_data
);

    logic [7:0]                    r_mem [bpdi_pkg::STORE_DEPTH];
    logic [bpdi_pkg::STORE_DEPTH-1:0] r_valid;
    logic [7:0]                    r_rd_data;
    logic                          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 8'h00;

endmodule

FILE: design/bpdi_alu.sv
// ----------------------------------------------------------------------------
// bpdi_alu
// Shared 8-bit unit: add, subtract, xor and rotate of the accumulator.
// ----------------------------------------------------------------------------
module bpdi_alu (
    input  logic [7:0]          i_acc,
    input  bpdi_pkg::t_alu_ctl  i_ctl,
    output logic [7:0]          o_result
);

    logic [2:0]  w_lcount;
    logic [15:0] w_dbl;

    // Right rotate is a left rotate by the negated count
    assign w_lcount = (i_ctl.fn == bpdi_pkg::FN_ROR) ? (3'd0 - i_ctl.operand[2:0])
                                                     : i_ctl.operand[2:0];
    assign w_dbl    = {i_acc, i_acc} << w_lcount;

    always_comb begin
        unique case (i_ctl.fn)
            bpdi_pkg::FN_ADD: o_result = i_acc + i_ctl.operand;
            bpdi_pkg::FN_SUB: o_result = i_acc - i_ctl.operand;
            bpdi_pkg::FN_XOR: o_result = i_acc ^ i_ctl.operand;
            bpdi_pkg::FN_ROL,
            bpdi_pkg::FN_ROR: o_result = w_dbl[15:8];
            default:          o_result = i_acc;
        endcase
    end

endmodule

FILE: sim/byte_program_decrypt_interpreter_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_program_decrypt_interpreter_monitor
// Watches both channels of the interpreter. It keeps its own program store,
// key and abort flag, and predicts each decrypted byte when its transaction
// is accepted. It compares every returned byte with the oldest prediction.
// ----------------------------------------------------------------------------
module byte_program_decrypt_interpreter_monitor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  bpdi_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  bpdi_pkg::t_out_item i_out,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [7:0]          prog_mem [bpdi_pkg::STORE_DEPTH];
    logic [7:0]          run_key;
    logic                run_halted;
    bpdi_pkg::t_out_item plain_q [$];
    int                  mismatch_count = 0;
    int                  pending_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_count;

    function automatic logic [7:0] rot_left(input logic [7:0] v, input logic [7:0] n);
        logic [15:0] w;
        w = {v, v} << n[2:0];
        return w[15:8];
    endfunction

    function automatic logic [7:0] rot_right(input logic [7:0] v, input logic [7:0] n);
        logic [15:0] w;
        w = {v, v} >> n[2:0];
        return w[7:0];
    endfunction

    function automatic logic [7:0] mem_at(input int pos);
        return prog_mem[bpdi_pkg::ADDR_W'(pos % bpdi_pkg::STORE_DEPTH)];
    endfunction

    // Run the stored program on one byte; return the status code.
    function automatic logic [1:0] decrypt_byte(input logic [7:0] data, input logic [7:0] key,
                                                output logic [7:0] plain);
        logic [7:0] acc;
        logic [7:0] op;
        logic [7:0] arg;
        int         pc;
        int         steps;
        acc   = data;
        pc    = 0;
        steps = 0;
        plain = data;
        while (pc >= 0 && pc < bpdi_pkg::PROGRAM_LEN) begin
            if (steps >= bpdi_pkg::MAX_STEPS)
                return bpdi_pkg::STAT_STEPS;
            steps++;
            op  = mem_at(pc);
            arg = mem_at(pc + 1);
            case (op)
                bpdi_pkg::OP_JMP: begin
                    pc = pc + 2 + (arg[7] ? int'(arg) - 256 : int'(arg));
                end
                bpdi_pkg::OP_DEC:  begin acc = acc - 8'd1; pc += 2; end
                bpdi_pkg::OP_SUBK: begin acc = acc - key;  pc += 2; end
                bpdi_pkg::OP_ADDK: begin acc = acc + key;  pc += 2; end
                bpdi_pkg::OP_XORK: begin acc = acc ^ key;  pc += 2; end
                bpdi_pkg::OP_ADDI: begin acc = acc + arg;  pc += 2; end
                bpdi_pkg::OP_XORI: begin acc = acc ^ arg;  pc += 2; end
                bpdi_pkg::OP_SUBI: begin acc = acc - arg;  pc += 2; end
                bpdi_pkg::OP_ROTI: begin
                    if (arg == bpdi_pkg::MOD_ROL)
                        acc = rot_left(acc, mem_at(pc + 2));
                    else
                        acc = rot_right(acc, mem_at(pc + 2));
                    pc += 3;
                end
                // Three bytes long even though only the mode byte is read
                bpdi_pkg::OP_ROTK: begin
                    if (arg == bpdi_pkg::MOD_ROR)
                        acc = rot_right(acc, key);
                    else
                        acc = rot_left(acc, key);
                    pc += 3;
                end
                bpdi_pkg::OP_NOP0, bpdi_pkg::OP_NOP1, bpdi_pkg::OP_NOP2: pc += 1;
                default: return bpdi_pkg::STAT_BADOP;
            endcase
        end
        plain = acc;
        return bpdi_pkg::STAT_OK;
    endfunction

    always @(posedge i_clk) begin : track
        bpdi_pkg::t_out_item want;
        bpdi_pkg::t_out_item got;
        logic [7:0] plain;
        logic [1:0] st;
        if (!i_rst_n) begin
            for (int k = 0; k < bpdi_pkg::STORE_DEPTH; k++)
                prog_mem[bpdi_pkg::ADDR_W'(k)] = 8'h00;
            run_key    = 8'h00;
            run_halted = 1'b0;
            plain_q.delete();
            pending_count <= 0;
        end else begin
            // Retire the result first: it belongs to an earlier transaction
            if (i_out_valid && i_out_ready) begin
                got = i_out;
                if (plain_q.size() == 0) begin
                    $error("result with no prediction pending: plain_byte %02h, status %0d",
                           got.plain_byte, got.status);
                    mismatch_count++;
                end else begin
                    want = plain_q.pop_front();
                    if (got.plain_byte !== want.plain_byte) begin
                        $error("plain_byte mismatch: expected %02h, actual %02h",
                               want.plain_byte, got.plain_byte);
                        mismatch_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in.req_type)
                    bpdi_pkg::REQ_WRITE: prog_mem[i_in.prog_index] = i_in.prog_byte;
                    bpdi_pkg::REQ_START: begin
                        run_key    = i_in.run_length_low;
                        run_halted = 1'b0;
                    end
                    bpdi_pkg::REQ_DATA: begin
                        if (run_halted) begin
                            st    = bpdi_pkg::STAT_SKIP;
                            plain = i_in.data_byte;
                        end else begin
                            st = decrypt_byte(i_in.data_byte, run_key, plain);
                            if (st == bpdi_pkg::STAT_OK)
                                run_key = run_key - 8'd1;
                            else
                                run_halted = 1'b1;
                        end
                        want.plain_byte = plain;
                        want.status     = st;
                        plain_q.push_back(want);
                    end
                    default: ;
                endcase
            end
            pending_count <= plain_q.size();
        end
    end

endmodule

FILE: sim/byte_program_decrypt_interpreter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_program_decrypt_interpreter_tb
// Loads byte-code programs, starts runs and feeds data bytes with random
// gaps and stalls on both channels. A directed opening covers the error
// paths and the rotate quirk; random programs follow. The monitor beside
// the block predicts and checks every result.
// ----------------------------------------------------------------------------
module byte_program_decrypt_interpreter_tb;

    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam int         ITEM_TARGET  = 2000;
    localparam int         STALL_LIMIT  = 40000;
    localparam int         HOLD_CYCLES  = 400;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    bpdi_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    bpdi_pkg::t_out_item out_item;
    int                  fail_count;
    int                  pending;
    int                  items_sent = 0;
    int                  tx_burst = 0;
    int                  rx_burst = 0;
    int                  stall_cycles = 0;

    byte_program_decrypt_interpreter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    byte_program_decrypt_interpreter_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            burst = $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Offer one transaction and hold it until accepted.
    task automatic send_item(input bpdi_pkg::t_in_item item);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        if (item.req_type != REQ_RESERVED)
            items_sent++;
    endtask

    function automatic bpdi_pkg::t_in_item noisy_fields(input logic [1:0] kind);
        bpdi_pkg::t_in_item item;
        item.req_type       = kind;
        item.prog_index     = 6'($urandom);
        item.prog_byte      = 8'($urandom);
        item.run_length_low = 8'($urandom);
        item.data_byte      = 8'($urandom);
        return item;
    endfunction

    task automatic send_write(input logic [5:0] idx, input logic [7:0] value);
        bpdi_pkg::t_in_item item;
        item            = noisy_fields(bpdi_pkg::REQ_WRITE);
        item.prog_index = idx;
        item.prog_byte  = value;
        send_item(item);
    endtask

    task automatic send_start(input logic [7:0] key);
        bpdi_pkg::t_in_item item;
        item                = noisy_fields(bpdi_pkg::REQ_START);
        item.run_length_low = key;
        send_item(item);
    endtask

    task automatic send_data(input logic [7:0] value);
        bpdi_pkg::t_in_item item;
        item           = noisy_fields(bpdi_pkg::REQ_DATA);
        item.data_byte = value;
        send_item(item);
    endtask

    // Result side: random stalls, bursts, and two long hold-offs.
    initial begin : receiver
        int gap;
        int taken;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (taken == 60 || taken == 700) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                gap = draw_gap(rx_burst);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("byte_program_decrypt_interpreter_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] img [bpdi_pkg::STORE_DEPTH];
        logic [7:0] key;
        int         idx;
        int         kind;
        int         dist_fwd;
        int         ndata;
        int         n;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty store after reset: opcode zero is unknown, then skip
        send_data(8'h00);
        send_data(8'hFF);
        // Jump to itself until the step limit trips
        send_start(8'hFF);
        send_write(6'd0, bpdi_pkg::OP_JMP);
        send_write(6'd1, 8'hFE);
        send_data(8'h5A);
        send_data(8'hA5);
        // Forward jump out of range: byte passes through, key 00 wraps
        send_start(8'h00);
        send_write(6'd1, 8'h7F);
        send_data(8'h00);
        // XOR key then a backward jump below zero
        send_write(6'd0, bpdi_pkg::OP_XORK);
        send_write(6'd2, bpdi_pkg::OP_JMP);
        send_write(6'd3, 8'h80);
        send_data(8'hFF);
        send_item(noisy_fields(REQ_RESERVED));
        send_write(6'd63, bpdi_pkg::OP_ROTI);
        // Rotate by key in both modes, three bytes each
        send_write(6'd2, bpdi_pkg::OP_ROTK);
        send_write(6'd3, bpdi_pkg::MOD_ROR);
        send_write(6'd5, bpdi_pkg::OP_JMP);
        send_write(6'd6, 8'h80);
        send_data(8'h81);
        send_write(6'd3, 8'h00);
        send_data(8'h81);
        send_start(8'hFF);
        send_data(8'h00);

        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 3);
            if (kind <= 1) begin
                for (int k = 0; k < bpdi_pkg::STORE_DEPTH; k++)
                    img[6'(k)] = 8'($urandom);
                idx = 0;
                while (idx < bpdi_pkg::PROGRAM_LEN) begin
                    kind = $urandom_range(0, 199);
                    if (kind == 0) begin
                        img[6'(idx)] = 8'($urandom);
                        idx += 1;
                    end else if (kind == 1) begin
                        img[6'(idx)]     = bpdi_pkg::OP_JMP;
                        img[6'(idx + 1)] = 8'($urandom_range(128, 255));
                        idx += 2;
                    end else if (kind < 20) begin
                        case ($urandom_range(0, 2))
                            0: img[6'(idx)] = bpdi_pkg::OP_NOP0;
                            1: img[6'(idx)] = bpdi_pkg::OP_NOP1;
                            default: img[6'(idx)] = bpdi_pkg::OP_NOP2;
                        endcase
                        idx += 1;
                    end else if (kind < 90) begin
                        case ($urandom_range(0, 6))
                            0: img[6'(idx)] = bpdi_pkg::OP_ADDI;
                            1: img[6'(idx)] = bpdi_pkg::OP_SUBI;
                            2: img[6'(idx)] = bpdi_pkg::OP_XORI;
                            3: img[6'(idx)] = bpdi_pkg::OP_ADDK;
                            4: img[6'(idx)] = bpdi_pkg::OP_SUBK;
                            5: img[6'(idx)] = bpdi_pkg::OP_XORK;
                            default: img[6'(idx)] = bpdi_pkg::OP_DEC;
                        endcase
                        img[6'(idx + 1)] = 8'($urandom);
                        idx += 2;
                    end else if (kind < 120) begin
                        img[6'(idx)] = bpdi_pkg::OP_ROTI;
                        if ($urandom_range(0, 1) == 1)
                            img[6'(idx + 1)] = bpdi_pkg::MOD_ROL;
                        idx += 3;
                    end else if (kind < 150) begin
                        img[6'(idx)] = bpdi_pkg::OP_ROTK;
                        if ($urandom_range(0, 1) == 1)
                            img[6'(idx + 1)] = bpdi_pkg::MOD_ROR;
                        idx += 3;
                    end else begin
                        // Skip over garbage so the target stays aligned
                        if ($urandom_range(0, 7) == 0)
                            dist_fwd = $urandom_range(0, 127);
                        else
                            dist_fwd = $urandom_range(0, 4);
                        img[6'(idx)]     = bpdi_pkg::OP_JMP;
                        img[6'(idx + 1)] = 8'(dist_fwd);
                        idx += 2 + dist_fwd;
                    end
                end
                for (int k = 0; k < bpdi_pkg::STORE_DEPTH; k++)
                    send_write(6'(k), img[6'(k)]);
            end else if (kind == 2) begin
                n = $urandom_range(1, 4);
                repeat (n) send_write(6'($urandom), 8'($urandom));
            end

            if ($urandom_range(0, 7) != 0) begin
                case ($urandom_range(0, 7))
                    0: key = 8'h00;
                    1: key = 8'hFF;
                    default: key = 8'($urandom);
                endcase
                send_start(key);
            end

            ndata = $urandom_range(4, 60);
            repeat (ndata) begin
                kind = $urandom_range(0, 31);
                if (kind == 0)
                    send_write(6'($urandom), 8'($urandom));
                else if (kind == 1)
                    send_item(noisy_fields(REQ_RESERVED));
                else if (kind == 2)
                    send_start(8'($urandom));
                send_data(8'($urandom));
            end
        end

        in_valid <= 1'b0;
        // Let the monitor count the last transaction before waiting on it
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("byte_program_decrypt_interpreter_tb: PASS");
        else
            $display("byte_program_decrypt_interpreter_tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/bpdi_pkg.sv
design/bpdi_prog_mem.sv
design/bpdi_alu.sv
design/byte_program_decrypt_interpreter.sv
sim/byte_program_decrypt_interpreter_monitor.sv
sim/byte_program_decrypt_interpreter_tb.sv
